### src/arh_pkg.sv
// ----------------------------------------------------------------------------
// arh_pkg: shared types, constants and helpers
// Widths, exponent limits, command codes, bank control word and the
// saturating arithmetic used by the auto-ranging histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package arh_pkg;

	localparam int CNT_W    = 32;
	localparam int SMP_W    = 32;
	localparam int EXP_W    = 6;
	localparam int IDX_W    = 6;
	localparam int PADDR_W  = 3;
	localparam int BINS_DEF = 32;

	localparam logic signed [EXP_W-1:0] EXP_MIN     = -6'sd8;
	localparam logic signed [EXP_W-1:0] EXP_MAX     = 6'sd24;
	localparam logic signed [EXP_W-1:0] START_RESET = 6'sd0;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// register index (byte address / 4)
	localparam logic REG_START = 1'b0;

	typedef struct packed {
		logic re;
		logic we;
		logic clr_all;
		logic clr_upper;
	} bank_ctl_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[CNT_W] ? {CNT_W{1'b1}} : t[CNT_W-1:0];
	endfunction

	function automatic logic signed [EXP_W-1:0] clamp_exp(input logic signed [EXP_W-1:0] v);
		logic signed [EXP_W-1:0] r;
		r = v;
		if (v < EXP_MIN) r = EXP_MIN;
		if (v > EXP_MAX) r = EXP_MAX;
		return r;
	endfunction

endpackage

`default_nettype wire

### src/arh_bank.sv
// ----------------------------------------------------------------------------
// arh_bank: bin counter memory
// One-write, one-read synchronous RAM with registered read data, plus a
// per-entry valid bit so a full clear or an upper-half clear only drops valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_bank #(
	parameter int NB = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  arh_pkg::bank_ctl_t        ctl,
	input  wire [$clog2(NB)-1:0]      raddr,
	input  wire [$clog2(NB)-1:0]      waddr,
	input  wire [arh_pkg::CNT_W-1:0]  wdata,
	output logic [arh_pkg::CNT_W-1:0] rdata
);
	import arh_pkg::*;

	localparam int AW = $clog2(NB);
	localparam int HB = NB / 2;

	logic [CNT_W-1:0] mem_q [NB];
	logic [NB-1:0]    vld_q;
	logic [CNT_W-1:0] rd_s1;
	logic             rdv_s1;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.re) begin
			rd_s1 <= mem_q[raddr];
		end
	end

	// invalid entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			if (ctl.re) begin
				rdv_s1 <= vld_q[raddr];
			end
			for (int k = 0; k < NB; k++) begin
				if (ctl.clr_all || (ctl.clr_upper && k >= HB)) begin
					vld_q[k] <= 1'b0;
				end else if (ctl.we && waddr == AW'(k)) begin
					vld_q[k] <= 1'b1;
				end
			end
		end
	end

	assign rdata = rdv_s1 ? rd_s1 : '0;

`ifndef SYNTH
	// the sequencer never reads the entry it writes in the same cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.we && ctl.re && waddr == raddr))
		else $error("bank read and write hit the same entry");
	a_clr_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_all |-> !ctl.we)
		else $error("write during full clear");
	a_merge_low: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.we && ctl.clr_upper) |-> (waddr < AW'(HB)))
		else $error("merge write into cleared upper half");
`endif

endmodule

`default_nettype wire

### src/auto_ranging_histogram_unit.sv
// ----------------------------------------------------------------------------
// auto_ranging_histogram_unit: histogram with power-of-two auto ranging
// Counts samples into NB bins whose width doubles on overflow below EXP_MAX,
// and dumps and clears all bins on a flush, shrinking the range afterwards.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive cmd/sample with start; the word is taken at a
//    clock edge with start high and busy low. cmd=insert counts sample,
//    cmd=flush dumps the bins.
//  - Result channel: a flush emits NB words, one per cycle, each marked by
//    valid for one cycle (bin_index, bin_count, range_exponent, last_bin).
//    The receiver cannot stall; words pass the bank and output registers.
//  - Insert in range: counter read, then write back.
//    Each range doubling reads each bin once through the single bank
//    read port and merges the bins in pairs (S_EXA, S_EXB), then S_EXL, S_CHK.
//  - Flush: NB bin reads, then range halvings, one per cycle.
//  - start_exponent at byte address 0 via APB; a write clears all bins
//    (their valid bits drop) and reloads the exponent, clamped to
//    [-8, 24]. Write only while busy is low.
//  - Reset: all bins zero, exponent 0, no clearing pass needed.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_ranging_histogram_unit #(
	parameter int BINS = arh_pkg::BINS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// config port
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire [arh_pkg::PADDR_W-1:0]        paddr,
	input  wire [31:0]                        pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// command channel
	input  wire                               start,
	output logic                              busy,
	input  wire                               cmd,
	input  wire [arh_pkg::SMP_W-1:0]          sample,
	// result channel
	output logic                              valid,
	output logic [arh_pkg::IDX_W-1:0]         bin_index,
	output logic [arh_pkg::CNT_W-1:0]         bin_count,
	output logic signed [arh_pkg::EXP_W-1:0]  range_exponent,
	output logic                              last_bin
);
	import arh_pkg::*;

	localparam int NB = 2 * (BINS / 2);       // even bin count actually used
	localparam int HB = NB / 2;
	localparam int AW = $clog2(NB);
	localparam int PW = (HB > 1) ? $clog2(HB) : 1;
	localparam int SW = AW + 10;              // (L+1) << up to 9
	localparam int XW = SMP_W + 8;            // sample with 8 fraction bits

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_UPD  = 9'b000000010,
		S_EXA  = 9'b000000100,
		S_EXB  = 9'b000001000,
		S_EXL  = 9'b000010000,
		S_CHK  = 9'b000100000,
		S_FL   = 9'b001000000,
		S_DRN  = 9'b010000000,
		S_SHR  = 9'b100000000
	} state_t;

	state_t                   state_q, state_d;
	logic signed [EXP_W-1:0]  exp_q;
	logic [EXP_W-1:0]         cfg_q;
	logic [SMP_W-1:0]         sample_q;
	logic [AW-1:0]            idx_q;     // insert target bin
	logic [PW-1:0]            pair_q;    // merge pair index
	logic [CNT_W-1:0]         even_q;    // even bin of current pair
	logic [AW-1:0]            fidx_q;    // flush read index
	logic [AW-1:0]            hi_q;      // highest nonzero bin seen in flush
	logic [3:0]               h_q;       // halvings done
	logic                     fl_s1;
	logic [AW-1:0]            fidx_s1;

	logic                     valid_q, last_q;
	logic [IDX_W-1:0]         bidx_q;
	logic [CNT_W-1:0]         bcnt_q;
	logic signed [EXP_W-1:0]  rexp_q;

	bank_ctl_t                ctl;
	logic [AW-1:0]            raddr, waddr;
	logic [CNT_W-1:0]         wdata, rdata;

	logic                     cfg_wr;
	logic [SMP_W-1:0]         smp_src;
	logic [EXP_W-1:0]         shamt;
	logic [XW-1:0]            scaled;
	logic                     oor, grow;
	logic [AW-1:0]            ins_idx;
	logic [SW-1:0]            span;
	logic                     shr_go;
	logic                     pair_last, fl_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_START);
	assign prdata = (paddr[PADDR_W-1] == REG_START) ? {{(32-EXP_W){1'b0}}, cfg_q} : '0;

	assign busy = (state_q != S_IDLE);

	// bin of sample: {s, 8'b0} >> (e+8) covers both shift directions
	assign smp_src = (state_q == S_CHK) ? sample_q : sample;
	assign shamt   = EXP_W'(unsigned'(exp_q)) + EXP_W'(8);
	assign scaled  = {smp_src, 8'b0} >> shamt;
	assign oor     = (scaled >= XW'(NB));
	assign grow    = oor && (exp_q != EXP_MAX);
	assign ins_idx = oor ? AW'(NB - 1) : scaled[AW-1:0];

	assign pair_last = (pair_q == PW'(HB - 1));
	assign fl_last   = (fidx_q == AW'(NB - 1));

	// shrink while (L+1) * 2^(h+1) < NB
	assign span   = (SW'(hi_q) + SW'(1)) << (h_q + 4'd1);
	assign shr_go = (span < SW'(NB)) && (exp_q > EXP_MIN) && (h_q < 4'd8);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		raddr   = '0;
		waddr   = '0;
		wdata   = '0;
		case (state_q)
			S_IDLE, S_CHK: begin
				if (state_q == S_CHK || (start && cmd == CMD_INSERT)) begin
					if (grow) begin
						state_d = S_EXA;
					end else begin
						ctl.re  = 1'b1;
						raddr   = ins_idx;
						state_d = S_UPD;
					end
				end else if (start) begin
					state_d = S_FL;
				end
			end
			S_UPD: begin
				ctl.we  = 1'b1;
				waddr   = idx_q;
				wdata   = sat_add(rdata, CNT_W'(1));
				state_d = S_IDLE;
			end
			S_EXA: begin
				ctl.re = 1'b1;
				raddr  = AW'({pair_q, 1'b0});
				if (pair_q != '0) begin
					// odd bin of previous pair is on rdata now
					ctl.we = 1'b1;
					waddr  = AW'(pair_q - PW'(1));
					wdata  = sat_add(even_q, rdata);
				end
				state_d = S_EXB;
			end
			S_EXB: begin
				ctl.re  = 1'b1;
				raddr   = AW'({pair_q, 1'b1});
				state_d = pair_last ? S_EXL : S_EXA;
			end
			S_EXL: begin
				ctl.we        = 1'b1;
				ctl.clr_upper = 1'b1;
				waddr         = AW'(HB - 1);
				wdata         = sat_add(even_q, rdata);
				state_d       = S_CHK;
			end
			S_FL: begin
				ctl.re = 1'b1;
				raddr  = fidx_q;
				if (fl_last) begin
					ctl.clr_all = 1'b1;
					state_d     = S_DRN;
				end
			end
			S_DRN: begin
				state_d = S_SHR;
			end
			S_SHR: begin
				if (!shr_go) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		ctl.clr_all = ctl.clr_all | cfg_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exp_q   <= clamp_exp(START_RESET);
			cfg_q   <= '0;
			fl_s1   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fl_s1   <= (state_q == S_FL);
			valid_q <= fl_s1;
			if (cfg_wr) begin
				cfg_q <= pwdata[EXP_W-1:0];
				exp_q <= clamp_exp(signed'(pwdata[EXP_W-1:0]));
			end else if (state_q == S_EXL) begin
				exp_q <= exp_q + 6'sd1;
			end else if (state_q == S_SHR && shr_go) begin
				exp_q <= exp_q - 6'sd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			sample_q <= sample;
			pair_q   <= '0;
			fidx_q   <= '0;
			hi_q     <= '0;
		end
		if (ctl.re && (state_q == S_IDLE || state_q == S_CHK)) begin
			idx_q <= ins_idx;
		end
		if (state_q == S_CHK) begin
			pair_q <= '0;
		end
		if (state_q == S_EXB) begin
			even_q <= rdata;
			if (!pair_last) pair_q <= pair_q + PW'(1);
		end
		if (state_q == S_FL) begin
			fidx_q <= fidx_q + AW'(1);
		end
		fidx_s1 <= fidx_q;
		if (state_q == S_DRN) begin
			h_q <= '0;
		end else if (state_q == S_SHR && shr_go) begin
			h_q <= h_q + 4'd1;
		end
		if (fl_s1) begin
			bidx_q <= IDX_W'(fidx_s1);
			bcnt_q <= rdata;
			rexp_q <= exp_q;
			last_q <= (fidx_s1 == AW'(NB - 1));
			if (rdata != '0) hi_q <= fidx_s1;
		end
	end

	assign valid          = valid_q;
	assign bin_index      = bidx_q;
	assign bin_count      = bcnt_q;
	assign range_exponent = rexp_q;
	assign last_bin       = last_q;

	arh_bank #(
		.NB(NB)
	) u_bank (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.raddr (raddr),
		.waddr (waddr),
		.wdata (wdata),
		.rdata (rdata)
	);

`ifndef SYNTH
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q >= EXP_MIN) && (exp_q <= EXP_MAX))
		else $error("range exponent out of bounds");
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last_bin) |=> !valid)
		else $error("word after last bin");
	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last_bin) |=> (valid && bin_index == $past(bin_index) + 6'd1))
		else $error("flush run broken");
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !fl_s1)
		else $error("idle with flush read in flight");
`endif

endmodule

`default_nettype wire
